FILE: sv/annexb_pkg.sv
// Shared types for the Annex-B NAL unit splitter.
// Holds the parser state record and the result record; no dependencies.
package annexb_pkg;

	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] BYTE_ONE    = 8'h01;
	localparam logic [4:0] TYPE_MASK   = 5'h1f;
	localparam logic [4:0] TYPE_SPS    = 5'd7;
	localparam logic [4:0] TYPE_PPS    = 5'd8;

	typedef struct packed {
		logic       inside_unit;
		logic [7:0] zero_run;
		logic       run_saturated;
		logic       unit_has_bytes;
		logic [4:0] current_type;
		logic       current_is_sps;
		logic       current_is_pps;
		logic       sps_seen;
		logic       pps_seen;
	} parse_state_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic       has_byte;
		logic [7:0] zeros_before;
		logic       zero_run_overflow;
		logic       unit_first;
		logic [4:0] unit_type;
		logic       unit_end;
		logic       first_sps;
		logic       first_pps;
		logic       packet_done;
		logic       sps_found;
		logic       pps_found;
	} result_t;

endpackage

FILE: sv/annexb_step.sv
// Per-byte parser step: next parser state and the optional result for one byte.
// Pure combinational; uses annexb_pkg.
module annexb_step import annexb_pkg::*; #(
	parameter int ZERO_RUN_MAX = 255
) (
	input  parse_state_t st,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output parse_state_t nxt,
	output result_t      res
);

	localparam int RunCapInt = (ZERO_RUN_MAX > 255) ? 255 : ZERO_RUN_MAX;
	localparam logic [7:0] RunCap = RunCapInt[7:0];

	logic       is_zero;
	logic       is_start;
	logic [4:0] first_type;

	assign is_zero    = (data_byte == BYTE_ZERO);
	assign is_start   = (data_byte == BYTE_ONE) && (st.zero_run >= 8'd2);
	assign first_type = (st.zero_run != 8'd0) ? 5'd0 : (data_byte[4:0] & TYPE_MASK);

	always_comb begin
		nxt = st;
		res = '0;
		if (is_zero) begin
			if (st.zero_run < RunCap)
				nxt.zero_run = st.zero_run + 8'd1;
			else
				nxt.run_saturated = 1'b1;
		end else if (is_start) begin
			// close the open unit; the held zeros belong to the start code
			if (st.inside_unit && st.unit_has_bytes) begin
				res.emit      = 1'b1;
				res.unit_end  = 1'b1;
				res.unit_type = st.current_type;
				res.first_sps = st.current_is_sps;
				res.first_pps = st.current_is_pps;
			end
			nxt.inside_unit    = 1'b1;
			nxt.unit_has_bytes = 1'b0;
			nxt.current_type   = 5'd0;
			nxt.current_is_sps = 1'b0;
			nxt.current_is_pps = 1'b0;
			nxt.zero_run       = 8'd0;
			nxt.run_saturated  = 1'b0;
		end else begin
			if (st.inside_unit) begin
				if (!st.unit_has_bytes) begin
					nxt.current_type   = first_type;
					nxt.current_is_sps = (first_type == TYPE_SPS) && !st.sps_seen;
					nxt.current_is_pps = (first_type == TYPE_PPS) && !st.pps_seen;
					if (first_type == TYPE_SPS)
						nxt.sps_seen = 1'b1;
					if (first_type == TYPE_PPS)
						nxt.pps_seen = 1'b1;
				end
				res.emit              = 1'b1;
				res.out_byte          = data_byte;
				res.has_byte          = 1'b1;
				res.zeros_before      = st.zero_run;
				res.zero_run_overflow = st.run_saturated;
				res.unit_first        = !st.unit_has_bytes;
				res.unit_type         = nxt.current_type;
				res.first_sps         = nxt.current_is_sps;
				res.first_pps         = nxt.current_is_pps;
				nxt.unit_has_bytes    = 1'b1;
			end
			nxt.zero_run      = 8'd0;
			nxt.run_saturated = 1'b0;
		end

		if (last_byte) begin
			// drop held zeros, report the summary, clear for the next packet
			if (nxt.inside_unit && nxt.unit_has_bytes) begin
				res.unit_type = nxt.current_type;
				res.first_sps = nxt.current_is_sps;
				res.first_pps = nxt.current_is_pps;
				res.unit_end  = 1'b1;
			end
			res.emit        = 1'b1;
			res.packet_done = 1'b1;
			res.sps_found   = nxt.sps_seen;
			res.pps_found   = nxt.pps_seen;
			nxt             = '0;
		end
	end

endmodule

FILE: sv/annexb_nal_splitter.sv
// Annex-B NAL unit splitter: top level with input register, parser state and
// result register. Depends on annexb_pkg and annexb_step.
//
// Usage:
//   Feed one packet byte per request on the input channel (data_byte, last_byte,
//   in_valid / in_stall). Results leave on the output channel (out_valid /
//   out_stall) with one port per field. A byte gives zero or one result; the
//   byte marked last_byte always gives one, carrying packet_done and the
//   sps_found / pps_found summary, and then the parser clears for the next packet.
//   An accepted byte waits in the input register; its result loads into the
//   result register as the byte advances, and out_valid rises with it.
//   Throughput: one byte per cycle unless a result is held up by out_stall; the
//   parser step is a byte compare and an 8-bit counter update between the input
//   register and the result register.
//   Zero bytes and bytes before the first start code, other than the last_byte,
//   give no result and never wait on the output side.
//   Reset (arst_n low) empties both registers and clears the parser state.
//   While out_stall holds a result, a byte that has a result of its own waits in
//   the input register and in_stall rises; bytes without a result pass through.
module annexb_nal_splitter import annexb_pkg::*; #(
	parameter int ZERO_RUN_MAX = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic [7:0] zeros_before,
	output logic       zero_run_overflow,
	output logic       unit_first,
	output logic [4:0] unit_type,
	output logic       unit_end,
	output logic       first_sps,
	output logic       first_pps,
	output logic       packet_done,
	output logic       sps_found,
	output logic       pps_found
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res;
	result_t      res_q;
	logic         out_valid_q;
	logic         out_blocked;
	logic         advance;
	logic         accept;

	annexb_step #(
		.ZERO_RUN_MAX(ZERO_RUN_MAX)
	) u_step (
		.st        (state_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	assign out_blocked = out_valid_q && out_stall;
	assign advance     = valid_s1 && !(res.emit && out_blocked);
	assign in_stall    = valid_s1 && !advance;
	assign accept      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// hold the result while stalled, load a new one when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_byte          = res_q.out_byte;
	assign has_byte          = res_q.has_byte;
	assign zeros_before      = res_q.zeros_before;
	assign zero_run_overflow = res_q.zero_run_overflow;
	assign unit_first        = res_q.unit_first;
	assign unit_type         = res_q.unit_type;
	assign unit_end          = res_q.unit_end;
	assign first_sps         = res_q.first_sps;
	assign first_pps         = res_q.first_pps;
	assign packet_done       = res_q.packet_done;
	assign sps_found         = res_q.sps_found;
	assign pps_found         = res_q.pps_found;

endmodule

FILE: verif/tb_annexb_nal_splitter.sv
`timescale 1ns / 1ps
// Testbench for annexb_nal_splitter: a directed table of Annex-B bytes, then random packets.
// Each result is checked against the in-bench model, or a typed row's own; uses annexb_pkg.
module tb_annexb_nal_splitter import annexb_pkg::*; ();

	localparam int RANDOM_BYTES = 900;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT        = 300000;
	localparam logic [7:0] RUN_CAP = 8'd255;

	localparam logic N = 1'b0;
	localparam logic Y = 1'b1;
	localparam logic [4:0] TYPE_NONE  = 5'd0;
	localparam logic [4:0] TYPE_SLICE = 5'd1;
	localparam logic [4:0] TYPE_IDR   = 5'd5;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [7:0] zeros_before;
		logic       zero_run_overflow;
		logic       unit_first;
		logic [4:0] unit_type;
		logic       unit_end;
		logic       first_sps;
		logic       first_pps;
		logic       packet_done;
		logic       sps_found;
		logic       pps_found;
	} nal_result_t;

	// typed: the row carries its own result; the model still runs but its result is not used
	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic        typed;
		nal_result_t want;
	} nal_req_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_t;

	localparam nal_result_t NO_RES = '0;

	// result order: byte, has, zeros, ovf, first, type, end, fsps, fpps, done, sps, pps
	localparam nal_req_t DIRECTED [27] = '{
		{8'hFF, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h01, N, N, NO_RES},
		{8'h67, N, Y, {8'h67, Y, 8'd0, N, Y, TYPE_SPS, N, Y, N, N, N, N}},
		{8'h00, N, N, NO_RES},
		// lone zero before 01 is unit data
		{8'h01, N, Y, {8'h01, Y, 8'd1, N, N, TYPE_SPS, N, Y, N, N, N, N}},
		{8'h00, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h01, N, Y, {8'h00, N, 8'd0, N, N, TYPE_SPS, Y, Y, N, N, N, N}},
		{8'h68, N, Y, {8'h68, Y, 8'd0, N, Y, TYPE_PPS, N, N, Y, N, N, N}},
		{8'h00, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h01, N, Y, {8'h00, N, 8'd0, N, N, TYPE_PPS, Y, N, Y, N, N, N}},
		{8'h00, N, N, NO_RES},
		// zero header byte gives type 0
		{8'h88, N, Y, {8'h88, Y, 8'd1, N, Y, TYPE_NONE, N, N, N, N, N, N}},
		{8'h00, Y, Y, {8'h00, N, 8'd0, N, N, TYPE_NONE, Y, N, N, Y, Y, Y}},
		{8'h7F, Y, Y, {8'h00, N, 8'd0, N, N, TYPE_NONE, N, N, N, Y, N, N}},
		{8'h00, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h01, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h00, N, N, NO_RES},
		{8'h01, N, N, NO_RES},
		{8'hE5, N, N, NO_RES},
		{8'hFF, Y, Y, {8'hFF, Y, 8'd0, N, N, TYPE_IDR, Y, N, N, Y, N, N}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [7:0] zeros_before;
	logic       zero_run_overflow;
	logic       unit_first;
	logic [4:0] unit_type;
	logic       unit_end;
	logic       first_sps;
	logic       first_pps;
	logic       packet_done;
	logic       sps_found;
	logic       pps_found;

	annexb_nal_splitter i_dut (.*);

	nal_req_t    byte_q[$];
	nal_result_t pending_q[$];
	nal_req_t    cur_req = '0;
	int          errors = 0;
	int          cycles = 0;
	int          total_bytes = 0;
	int          bytes_taken = 0;
	int          results_seen = 0;
	int          units_seen = 0;
	int          packets_seen = 0;
	int          saturated_seen = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          mode_left = 0;
	int          block_phase = 0;
	stall_mode_t stall_mode = STALL_NONE;

	// splitter model state
	logic       in_unit = 1'b0;
	logic [7:0] run_len = 8'd0;
	logic       run_sat = 1'b0;
	logic       unit_open = 1'b0;
	logic [4:0] cur_type = TYPE_NONE;
	logic       cur_sps = 1'b0;
	logic       cur_pps = 1'b0;
	logic       sps_hit = 1'b0;
	logic       pps_hit = 1'b0;

	initial forever #4 clk = ~clk;

	function automatic nal_result_t with_tags(nal_result_t r);
		r.unit_type = cur_type;
		r.first_sps = cur_sps;
		r.first_pps = cur_pps;
		return r;
	endfunction

	task automatic split_nal_byte(input logic [7:0] b, input logic fin,
			output bit got, output nal_result_t r);
		r = NO_RES;
		got = 1'b0;
		if (b == BYTE_ZERO) begin
			if (run_len < RUN_CAP)
				run_len++;
			else
				run_sat = 1'b1;
		end else if (b == BYTE_ONE && run_len >= 8'd2) begin
			// start code: close a unit that carried bytes, drop its trailing zeros
			if (in_unit && unit_open) begin
				r = with_tags(r);
				r.unit_end = 1'b1;
				got = 1'b1;
			end
			in_unit = 1'b1;
			unit_open = 1'b0;
			cur_type = TYPE_NONE;
			cur_sps = 1'b0;
			cur_pps = 1'b0;
			run_len = 8'd0;
			run_sat = 1'b0;
		end else begin
			if (in_unit) begin
				if (!unit_open) begin
					cur_type = (run_len != 8'd0) ? TYPE_NONE : (b[4:0] & TYPE_MASK);
					cur_sps = (cur_type == TYPE_SPS) && !sps_hit;
					cur_pps = (cur_type == TYPE_PPS) && !pps_hit;
					if (cur_type == TYPE_SPS)
						sps_hit = 1'b1;
					if (cur_type == TYPE_PPS)
						pps_hit = 1'b1;
				end
				r = with_tags(r);
				r.out_byte = b;
				r.has_byte = 1'b1;
				r.zeros_before = run_len;
				r.zero_run_overflow = run_sat;
				r.unit_first = !unit_open;
				unit_open = 1'b1;
				got = 1'b1;
			end
			run_len = 8'd0;
			run_sat = 1'b0;
		end
		if (fin) begin
			if (in_unit && unit_open) begin
				r = with_tags(r);
				r.unit_end = 1'b1;
			end
			r.packet_done = 1'b1;
			r.sps_found = sps_hit;
			r.pps_found = pps_hit;
			got = 1'b1;
			in_unit = 1'b0;
			run_len = 8'd0;
			run_sat = 1'b0;
			unit_open = 1'b0;
			cur_type = TYPE_NONE;
			cur_sps = 1'b0;
			cur_pps = 1'b0;
			sps_hit = 1'b0;
			pps_hit = 1'b0;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fin);
		nal_req_t req;
		req = {b, fin, N, NO_RES};
		byte_q = {byte_q, req};
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: return BYTE_ZERO;
			1: return BYTE_ONE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [4:0] pick_type();
		case ($urandom_range(0, 5))
			0: return TYPE_SPS;
			1: return TYPE_PPS;
			2: return TYPE_IDR;
			3: return TYPE_SLICE;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	task automatic gen_packet(input bit long_run);
		int n_units;
		if ($urandom_range(0, 9) == 0) begin
			// noise packet, rich in start code fragments
			repeat ($urandom_range(1, 24))
				add_byte(noise_byte(), N);
			add_byte(noise_byte(), Y);
			return;
		end
		repeat ($urandom_range(0, 3))
			add_byte(noise_byte(), N);
		n_units = $urandom_range(1, 5);
		for (int u = 0; u < n_units; u++) begin
			repeat ($urandom_range(2, 4))
				add_byte(BYTE_ZERO, N);
			add_byte(BYTE_ONE, N);
			if ($urandom_range(0, 9) == 0)
				continue;
			if ($urandom_range(0, 11) == 0)
				add_byte(BYTE_ZERO, N);
			add_byte({3'($urandom_range(0, 7)), pick_type()}, N);
			repeat ($urandom_range(0, 12)) begin
				case ($urandom_range(0, 9))
					0: repeat ($urandom_range(1, 3)) add_byte(BYTE_ZERO, N);
					1: begin
						add_byte(BYTE_ZERO, N);
						add_byte(BYTE_ONE, N);
					end
					default: add_byte(8'($urandom_range(0, 255)), N);
				endcase
			end
			// run the zero counter close to or past its cap, then release it with a data byte
			if (long_run && u == 0) begin
				repeat ($urandom_range(250, 300))
					add_byte(BYTE_ZERO, N);
				add_byte(8'($urandom_range(2, 255)), N);
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) add_byte(BYTE_ZERO, N);
		end
		add_byte(8'($urandom_range(0, 255)), Y);
	endtask

	task automatic check_field(input string name, input int unsigned w, input int unsigned g);
		if (w != g) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, w, g);
		end
	endtask

	always @(posedge clk) begin : feed_bytes
		bit          take;
		bit          nv;
		bit          got;
		nal_result_t r;
		take = in_valid && !in_stall;
		nv = in_valid && !take;
		if (take) begin
			split_nal_byte(cur_req.data, cur_req.fin, got, r);
			if (cur_req.typed)
				pending_q = {pending_q, cur_req.want};
			else if (got)
				pending_q = {pending_q, r};
			bytes_taken++;
		end
		// hold the request while stalled; otherwise advance, with bursts and gaps
		if (arst_n && !nv) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (byte_q.size() > 0) begin
				cur_req = byte_q.pop_front();
				nv = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		in_valid <= nv;
		data_byte <= cur_req.data;
		last_byte <= cur_req.fin;
	end

	always @(posedge clk) begin : stall_pattern
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 160);
		end else begin
			mode_left--;
		end
		block_phase = (block_phase + 1) % 11;
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 1) == 0);
			STALL_BLOCKS: out_stall <= (block_phase < 6);
		endcase
	end

	always @(posedge clk) begin : check_results
		nal_result_t got;
		nal_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_byte, has_byte, zeros_before, zero_run_overflow, unit_first, unit_type,
				unit_end, first_sps, first_pps, packet_done, sps_found, pps_found};
			results_seen++;
			if (got.unit_first)
				units_seen++;
			if (got.zero_run_overflow)
				saturated_seen++;
			if (got.packet_done)
				packets_seen++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual out_byte %0h done %0b",
					$time, got.out_byte, got.packet_done);
			end else begin
				want = pending_q.pop_front();
				check_field("out_byte", want.out_byte, got.out_byte);
				check_field("has_byte", want.has_byte, got.has_byte);
				check_field("zeros_before", want.zeros_before, got.zeros_before);
				check_field("zero_run_overflow", want.zero_run_overflow, got.zero_run_overflow);
				check_field("unit_first", want.unit_first, got.unit_first);
				check_field("unit_type", want.unit_type, got.unit_type);
				check_field("unit_end", want.unit_end, got.unit_end);
				check_field("first_sps", want.first_sps, got.first_sps);
				check_field("first_pps", want.first_pps, got.first_pps);
				check_field("packet_done", want.packet_done, got.packet_done);
				check_field("sps_found", want.sps_found, got.sps_found);
				check_field("pps_found", want.pps_found, got.pps_found);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : run_test
		int n_pkts;
		foreach (DIRECTED[i])
			byte_q = {byte_q, DIRECTED[i]};
		n_pkts = 0;
		while (byte_q.size() < $size(DIRECTED) + RANDOM_BYTES) begin
			gen_packet(n_pkts % 20 == 2);
			n_pkts++;
		end
		total_bytes = byte_q.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_taken < total_bytes)
			@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Fed %0d bytes; %0d results checked over %0d packets and %0d units,",
			total_bytes, results_seen, packets_seen, units_seen);
		$display("%0d of them released a saturated zero run; %0d mismatches.",
			saturated_seen, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
